// ===== hw/rtl/ssl_pkg.sv =====
// Shared types and constants for the SMBIOS structure locator.
package ssl_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [7:0] EndType = 8'd127;
  localparam logic [7:0] HeaderBytes = 8'd4;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TARGET_TYPE     = 2'd0,
    CFG_MINIMUM_LENGTH  = 2'd1,
    CFG_TABLE_LENGTH    = 2'd2,
    CFG_STRUCTURE_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    VERDICT_FOUND     = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_END_MARK  = 3'd2,
    VERDICT_COUNT_OUT = 3'd3,
    VERDICT_PAST_END  = 3'd4
  } verdict_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_STR  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]  target_type;
    logic [7:0]  minimum_length;
    logic [15:0] table_length;
    logic [15:0] structure_count;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_offset;
    logic [15:0] header_offset;
    logic [15:0] structure_index;
    logic [7:0]  header_type;
    logic [7:0]  skip_remaining;
    logic        previous_was_zero;
  } walk_state_t;

  typedef struct packed {
    logic        valid;
    verdict_t    verdict;
    logic [15:0] struct_offset;
    logic [7:0]  struct_length;
  } result_t;

endpackage

// ===== hw/rtl/ssl_walk_step.sv =====
// Per-byte next-state and verdict logic of the structure table walk.
module ssl_walk_step import ssl_pkg::*; (
  input  cfg_t        cfg,
  input  walk_state_t st,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output walk_state_t st_nxt,
  output result_t     res
);

  walk_state_t work;
  logic        go;
  logic [16:0] index_inc;
  logic [16:0] next_pos;
  logic [17:0] pos_end;
  logic [16:0] hdr_end;
  logic        no_room_count;

  always_comb begin
    work          = st;
    res           = '0;
    res.verdict   = VERDICT_FOUND;
    go            = 1'b0;
    index_inc     = {1'b0, st.structure_index} + 17'd1;
    next_pos      = 17'd0;
    pos_end       = 18'd0;
    hdr_end       = 17'd0;
    no_room_count = index_inc >= {1'b0, cfg.structure_count};

    if (first_byte) begin
      work.byte_offset       = '0;
      work.structure_index   = '0;
      work.previous_was_zero = 1'b0;
      work.skip_remaining    = '0;
      if (cfg.structure_count == 16'd0) begin
        res.valid   = 1'b1;
        res.verdict = VERDICT_COUNT_OUT;
        work.phase  = PH_IDLE;
      end else if (cfg.table_length < {8'd0, HeaderBytes}) begin
        res.valid   = 1'b1;
        res.verdict = VERDICT_PAST_END;
        work.phase  = PH_IDLE;
      end else begin
        work.header_offset = '0;
        work.phase         = PH_TYPE;
        go                 = 1'b1;
      end
    end else if (st.phase != PH_IDLE) begin
      work.byte_offset = st.byte_offset + 16'd1;
      go               = 1'b1;
    end

    if (go) begin
      unique case (work.phase)
        PH_TYPE: begin
          work.header_type = data_byte;
          work.phase       = PH_LEN;
        end
        PH_LEN: begin
          hdr_end = {1'b0, work.header_offset} + {9'd0, data_byte} + 17'd1;
          if (data_byte < HeaderBytes || work.header_type == EndType) begin
            res.valid         = 1'b1;
            res.verdict       = VERDICT_END_MARK;
            res.struct_offset = work.header_offset;
            res.struct_length = data_byte;
            work.phase        = PH_IDLE;
          end else if (work.header_type == cfg.target_type) begin
            res.valid         = 1'b1;
            res.verdict       = (data_byte >= cfg.minimum_length) ? VERDICT_FOUND
                                                                  : VERDICT_TOO_SHORT;
            res.struct_offset = work.header_offset;
            res.struct_length = data_byte;
            work.phase        = PH_IDLE;
          end else if (hdr_end >= {1'b0, cfg.table_length}) begin
            res.valid   = 1'b1;
            res.verdict = no_room_count ? VERDICT_COUNT_OUT : VERDICT_PAST_END;
            work.phase  = PH_IDLE;
          end else begin
            work.skip_remaining = data_byte - 8'd2;
            work.phase          = PH_SKIP;
          end
        end
        PH_SKIP: begin
          work.skip_remaining = work.skip_remaining - 8'd1;
          if (work.skip_remaining == 8'd0) begin
            work.previous_was_zero = 1'b0;
            work.phase             = PH_STR;
          end
        end
        PH_STR: begin
          next_pos = {1'b0, work.byte_offset} + 17'd1;
          if (work.previous_was_zero && data_byte == ZeroByte) begin
            // Double zero closes the structure; the next header starts here + 1.
            work.structure_index = index_inc[15:0];
            pos_end = {1'b0, next_pos} + {10'd0, HeaderBytes};
            if (index_inc >= {1'b0, cfg.structure_count}) begin
              res.valid   = 1'b1;
              res.verdict = VERDICT_COUNT_OUT;
              work.phase  = PH_IDLE;
            end else if (pos_end > {2'd0, cfg.table_length}) begin
              res.valid   = 1'b1;
              res.verdict = VERDICT_PAST_END;
              work.phase  = PH_IDLE;
            end else begin
              work.header_offset = next_pos[15:0];
              work.phase         = PH_TYPE;
            end
          end else if (next_pos >= {1'b0, cfg.table_length}) begin
            res.valid   = 1'b1;
            res.verdict = no_room_count ? VERDICT_COUNT_OUT : VERDICT_PAST_END;
            work.phase  = PH_IDLE;
          end else begin
            work.previous_was_zero = (data_byte == ZeroByte);
          end
        end
        default: begin
        end
      endcase

      if (!res.valid && last_byte && work.phase != PH_IDLE) begin
        res.valid   = 1'b1;
        res.verdict = VERDICT_PAST_END;
        work.phase  = PH_IDLE;
      end
    end

    st_nxt = work;
  end

endmodule

// ===== hw/rtl/smbios_structure_locator.sv =====
// Top level of the SMBIOS structure locator: handshakes, registers, config.
//
// Usage: table bytes arrive on the in_ channel, one byte per item, in table
// order. in_tuser[0] marks the byte at offset zero and starts a new search;
// in_tlast marks the last byte supplied. Each search gives at most one item
// on the out_ channel: verdict, offset of the deciding header and its
// formatted length. Bytes after a verdict are dropped until the next first
// byte. Registers are written through cfg_we/cfg_index/cfg_wdata while idle.
//
// Order: an accepted byte waits in the input register until the step advances;
// its result item is then presented from the result register.
// Throughput: one byte per cycle while the result side does not stall; the
// walk state updates through short logic between the input and result registers.
// Stall: while a result waits on out_tready the input register holds and
// in_tready drops once it is full; nothing is lost or repeated.
// Reset (rst_n low, synchronous): walk goes idle, registers clear to zero,
// both registers are emptied.
module smbios_structure_locator import ssl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  // table byte items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic [0:0]             in_tuser,   // [0] first_byte
  input  logic                   in_tlast,   // last_byte
  // verdict items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata   // [2:0] verdict, [18:3] struct_offset,
                                             // [26:19] struct_length, [31:27] zero
);

  cfg_t        cfg_r;
  walk_state_t st_r, st_nxt;
  result_t     res;

  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        in_first_r;
  logic        in_last_r;

  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic [15:0] out_offset_r;
  logic [7:0]  out_length_r;

  logic        advance;

  // The step only runs when a fresh result has somewhere to go.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET_TYPE:     cfg_r.target_type     <= cfg_wdata[7:0];
        CFG_MINIMUM_LENGTH:  cfg_r.minimum_length  <= cfg_wdata[7:0];
        CFG_TABLE_LENGTH:    cfg_r.table_length    <= cfg_wdata;
        CFG_STRUCTURE_COUNT: cfg_r.structure_count <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r  <= in_tdata;
      in_first_r <= in_tuser[0];
      in_last_r  <= in_tlast;
    end
  end

  ssl_walk_step u_step (
    .cfg        (cfg_r),
    .st         (st_r),
    .data_byte  (in_data_r),
    .first_byte (in_first_r),
    .last_byte  (in_last_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  // walk state; phase leads the struct, everything else clears to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= {PH_IDLE, {($bits(walk_state_t) - $bits(phase_t)){1'b0}}};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_verdict_r <= res.verdict;
      out_offset_r  <= res.struct_offset;
      out_length_r  <= res.struct_length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_length_r, out_offset_r, out_verdict_r};

endmodule

// ===== tb/smbios_structure_locator_check.sv =====
// Checker for the SMBIOS structure locator: table-walk predictor and verdict scoreboard.
module smbios_structure_locator_check import ssl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic [0:0]             in_tuser,   // [0] first_byte
  input  logic                   in_tlast,   // last_byte
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [31:0]            out_tdata,  // [2:0] verdict, [18:3] offset, [26:19] length
  output int                     errors,
  output int                     pending,
  output int                     verdicts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    verdict_t    verdict;
    logic [15:0] offset;
    logic [7:0]  length;
  } verdict_item_t;

  verdict_item_t expected_verdicts[$];
  int            seen_count;

  // register copies and walk state of the predictor
  cfg_t        regs;
  phase_t      walk_phase;
  logic [15:0] byte_pos;
  logic [15:0] hdr_pos;
  logic [15:0] struct_idx;
  logic [7:0]  hdr_type;
  logic [7:0]  skip_left;
  logic        prev_zero;

  initial errors = 0;

  task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    errors++;
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
  endtask

  task automatic post_verdict(input verdict_t v, input logic [15:0] off,
                              input logic [7:0] len);
    expected_verdicts.push_back('{verdict: v, offset: off, length: len});
    walk_phase = PH_IDLE;
  endtask

  // no room for another header: count verdict if this was the last counted structure
  task automatic post_no_room();
    if (struct_idx + 32'd1 >= regs.structure_count)
      post_verdict(VERDICT_COUNT_OUT, 16'd0, 8'd0);
    else
      post_verdict(VERDICT_PAST_END, 16'd0, 8'd0);
  endtask

  task automatic open_header(input int unsigned pos, output bit decided);
    decided = 1'b1;
    if (struct_idx >= regs.structure_count)
      post_verdict(VERDICT_COUNT_OUT, 16'd0, 8'd0);
    else if (pos + HeaderBytes > regs.table_length)
      post_verdict(VERDICT_PAST_END, 16'd0, 8'd0);
    else begin
      hdr_pos = pos[15:0];
      walk_phase = PH_TYPE;
      decided = 1'b0;
    end
  endtask

  // 32-bit literals keep the fit sums from wrapping at 16 bits
  task automatic walk_table_byte(input logic [7:0] data, input logic first, input logic last);
    bit decided;
    decided = 1'b0;
    if (first) begin
      byte_pos = '0;
      struct_idx = '0;
      prev_zero = 1'b0;
      skip_left = '0;
      open_header(0, decided);
    end else if (walk_phase == PH_IDLE) begin
      decided = 1'b1;
    end else begin
      byte_pos = byte_pos + 16'd1;
    end
    if (!decided) begin
      case (walk_phase)
        PH_TYPE: begin
          hdr_type = data;
          walk_phase = PH_LEN;
        end
        PH_LEN: begin
          decided = 1'b1;
          if (data < HeaderBytes || hdr_type == EndType)
            post_verdict(VERDICT_END_MARK, hdr_pos, data);
          else if (hdr_type == regs.target_type)
            post_verdict((data >= regs.minimum_length) ? VERDICT_FOUND : VERDICT_TOO_SHORT,
                         hdr_pos, data);
          else if (hdr_pos + data + 32'd1 >= regs.table_length)
            post_no_room();
          else begin
            skip_left = data - 8'd2;
            walk_phase = PH_SKIP;
            decided = 1'b0;
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) begin
            prev_zero = 1'b0;
            walk_phase = PH_STR;
          end
        end
        PH_STR: begin
          if (prev_zero && data == ZeroByte) begin
            struct_idx = struct_idx + 16'd1;
            open_header(byte_pos + 32'd1, decided);
          end else if (byte_pos + 32'd1 >= regs.table_length) begin
            post_no_room();
            decided = 1'b1;
          end else begin
            prev_zero = (data == ZeroByte);
          end
        end
        default: ;
      endcase
    end
    if (!decided && last && walk_phase != PH_IDLE)
      post_verdict(VERDICT_PAST_END, 16'd0, 8'd0);
  endtask

  always @(posedge clk) begin : scoreboard
    verdict_item_t want;
    if (!rst_n) begin
      regs = '0;
      walk_phase = PH_IDLE;
      byte_pos = '0;
      hdr_pos = '0;
      struct_idx = '0;
      hdr_type = '0;
      skip_left = '0;
      prev_zero = 1'b0;
      expected_verdicts.delete();
      seen_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_count++;
        if (expected_verdicts.size() == 0) begin
          flag("unexpected verdict item", 32'd0, out_tdata);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[2:0] !== want.verdict)
            flag("verdict", 32'(want.verdict), 32'(out_tdata[2:0]));
          if (out_tdata[18:3] !== want.offset)
            flag("struct_offset", 32'(want.offset), 32'(out_tdata[18:3]));
          if (out_tdata[26:19] !== want.length)
            flag("struct_length", 32'(want.length), 32'(out_tdata[26:19]));
          if (out_tdata[31:27] !== 5'd0)
            flag("padding", 32'd0, 32'(out_tdata[31:27]));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET_TYPE:     regs.target_type = cfg_wdata[7:0];
          CFG_MINIMUM_LENGTH:  regs.minimum_length = cfg_wdata[7:0];
          CFG_TABLE_LENGTH:    regs.table_length = cfg_wdata;
          CFG_STRUCTURE_COUNT: regs.structure_count = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        walk_table_byte(in_tdata, in_tuser[0], in_tlast);
    end
    pending <= expected_verdicts.size();
    verdicts_seen <= seen_count;
  end

endmodule

// ===== tb/smbios_structure_locator_test.sv =====
// Top of the SMBIOS structure locator testbench: clock, reset, table stimulus, verdict.
module smbios_structure_locator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssl_pkg::*;

  // generous limit for the slowest run
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       at_start;
    logic       at_end;
  } table_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] data_byte
  logic [0:0]             in_tuser = '0;   // [0] first_byte
  logic                   in_tlast = 1'b0; // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [31:0]            out_tdata;       // [2:0] verdict, [18:3] offset, [26:19] length

  int errors;
  int pending;
  int verdicts_seen;
  int cycles = 0;
  int bytes_sent = 0;
  int settings_count = 0;
  bit quiet = 1'b0;           // when set, neither side idles
  table_byte_t script[$];     // bytes of the table being built

  always #1 clk = ~clk;

  smbios_structure_locator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  smbios_structure_locator_check verdict_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .errors        (errors),
    .pending       (pending),
    .verdicts_seen (verdicts_seen)
  );

  // wait before each item, both sides
  function automatic int draw_wait();
    if (quiet)
      return 0;
    return $urandom_range(0, 15);
  endfunction

  // Result side: after each accepted verdict item, hold ready low for a drawn stall.
  always @(posedge clk) begin : ready_gen
    int nxt;
    int rdy_wait;
    if (!rst_n) begin
      rdy_wait = 0;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      nxt = draw_wait();
      rdy_wait = nxt;
      out_tready <= (nxt == 0);
    end else if (rdy_wait > 1) begin
      rdy_wait = rdy_wait - 1;
    end else begin
      rdy_wait = 0;
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
      $display("smbios_structure_locator: mismatch");
      $finish;
    end
  end

  task automatic put(input logic [7:0] d, input logic s, input logic e);
    script.push_back({d, s, e});
  endtask

  // Registers change only with the walk quiet: every predicted verdict delivered,
  // then a wait so a byte that gave no verdict has left the pipeline.
  task automatic program_regs(input logic [7:0] tt, input logic [7:0] ml,
                              input logic [15:0] tl, input logic [15:0] sc);
    logic [7:0] junk;
    junk = 8'($urandom);   // upper bits of the 8-bit registers are don't-care
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TARGET_TYPE;
    cfg_wdata <= {junk, tt};
    @(posedge clk);
    cfg_index <= CFG_MINIMUM_LENGTH;
    cfg_wdata <= {~junk, ml};
    @(posedge clk);
    cfg_index <= CFG_TABLE_LENGTH;
    cfg_wdata <= tl;
    @(posedge clk);
    cfg_index <= CFG_STRUCTURE_COUNT;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Stream the built table, one item per handshake, with a drawn gap before each.
  task automatic play();
    int gap;
    table_byte_t b;
    foreach (script[i]) begin
      b = script[i];
      gap = draw_wait();
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= b.byte_val;
      in_tuser <= b.at_start;
      in_tlast <= b.at_end;
      do @(posedge clk); while (in_tready !== 1'b1);
      bytes_sent++;
    end
    in_tvalid <= 1'b0;
    script.delete();
  endtask

  initial begin
    int n_structs, s, k, n_str, m, len_f, actual, pick;
    logic [7:0] typ, tt, ml;
    logic [15:0] tl, sc;
    logic [7:0] types[$];
    table_byte_t one;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed tables ----
    // byte without the first flag while idle: dropped
    program_regs(8'd1, 8'd0, 16'd4, 16'd1);
    put(8'hA5, 1'b0, 1'b0);
    play();
    // count used up and no room for a header: the count verdict wins
    program_regs(8'd1, 8'd0, 16'd0, 16'd0);
    put(8'h01, 1'b1, 1'b0);
    play();
    // header does not fit the table
    program_regs(8'd1, 8'd0, 16'd3, 16'd1);
    put(8'h01, 1'b1, 1'b0);
    play();
    // match at offset zero in a table that holds just one header
    program_regs(8'd1, 8'd0, 16'd4, 16'd1);
    put(8'h01, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    play();
    // match but shorter than the minimum, register extremes
    program_regs(8'd1, 8'hFF, 16'hFFFF, 16'hFFFF);
    put(8'h01, 1'b1, 1'b0);
    put(8'hFE, 1'b0, 1'b0);
    play();
    // end-of-table type
    program_regs(8'd1, 8'd0, 16'd100, 16'd5);
    put(EndType, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    play();
    // formatted length below a header
    program_regs(8'hFF, 8'd0, 16'd100, 16'd5);
    put(8'h05, 1'b1, 1'b0);
    put(8'h03, 1'b0, 1'b0);
    play();
    // formatted area runs past the table end on the last counted structure
    program_regs(8'd9, 8'd0, 16'd5, 16'd1);
    put(8'h02, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    play();
    // same, but the count still has room: past end
    program_regs(8'd9, 8'd0, 16'd5, 16'd2);
    put(8'h02, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    play();
    // stream ends with the search undecided
    program_regs(8'd1, 8'd0, 16'd100, 16'd1);
    put(8'h02, 1'b1, 1'b1);
    play();
    // restart mid-search, then walk one structure with an empty string area to a match
    program_regs(8'd1, 8'd0, 16'd100, 16'd4);
    put(8'h02, 1'b1, 1'b0);
    put(8'h02, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    put(8'hAA, 1'b0, 1'b0);
    put(8'h55, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h01, 1'b0, 1'b0);
    put(8'h04, 1'b0, 1'b1);
    play();

    // ---- random tables ----
    // Mostly well-formed tables with random contents and registers that mostly
    // agree with them; the rest are trimmed, restarted or pure noise.
    while (bytes_sent < 800) begin
      quiet = ($urandom_range(0, 3) == 0);
      types.delete();
      if ($urandom_range(0, 7) == 0) begin
        // noise: random bytes with random flags
        n_structs = $urandom_range(0, 3);
        types.push_back(8'($urandom));
        k = $urandom_range(1, 12);
        for (s = 0; s < k; s++)
          put(8'($urandom), $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0);
      end else begin
        n_structs = $urandom_range(1, 4);
        for (s = 0; s < n_structs; s++) begin
          if ($urandom_range(0, 1) == 0)
            typ = 8'($urandom_range(0, 7));
          else
            typ = 8'($urandom);
          pick = $urandom_range(0, 39);
          if (pick == 0)
            len_f = 255;
          else if (pick == 1)
            len_f = $urandom_range(0, 3);
          else
            len_f = $urandom_range(4, 12);
          types.push_back(typ);
          put(typ, s == 0, 1'b0);
          put(8'(len_f), 1'b0, 1'b0);
          for (k = 2; k < len_f; k++)
            put(8'($urandom), 1'b0, 1'b0);
          // string area: nonzero strings, each closed by a zero, then one more zero (two zeros if none)
          n_str = $urandom_range(0, 3);
          for (k = 0; k < n_str; k++) begin
            for (m = $urandom_range(1, 5); m > 0; m--)
              put(8'($urandom_range(1, 255)), 1'b0, 1'b0);
            put(ZeroByte, 1'b0, 1'b0);
          end
          if (n_str == 0)
            put(ZeroByte, 1'b0, 1'b0);
          put(ZeroByte, 1'b0, 1'b0);
        end
        if ($urandom_range(0, 1) == 0) begin
          // closing end-of-table structure
          put(EndType, 1'b0, 1'b0);
          put(HeaderBytes, 1'b0, 1'b0);
          put(8'($urandom), 1'b0, 1'b0);
          put(8'($urandom), 1'b0, 1'b0);
          put(ZeroByte, 1'b0, 1'b0);
          put(ZeroByte, 1'b0, 1'b0);
          n_structs++;
        end
        pick = $urandom_range(0, 9);
        if (pick != 0) begin
          if (pick == 1) begin
            // stream cut short
            k = $urandom_range(1, script.size());
            while (script.size() > k) script.delete(script.size() - 1);
          end
          one = script[script.size() - 1];
          one.at_end = 1'b1;
          script[script.size() - 1] = one;
        end
        if ($urandom_range(0, 9) == 0) begin
          // restart somewhere inside the table
          k = $urandom_range(0, script.size() - 1);
          one = script[k];
          one.at_start = 1'b1;
          script[k] = one;
        end
      end
      actual = script.size();

      pick = $urandom_range(0, 19);
      if (pick < 14)      tl = 16'(actual);
      else if (pick < 16) tl = 16'($urandom_range(0, actual));
      else if (pick < 18) tl = 16'(actual + $urandom_range(1, 20));
      else if (pick == 18) tl = 16'd0;
      else                tl = 16'hFFFF;

      pick = $urandom_range(0, 19);
      if (pick < 14)      sc = 16'(n_structs);
      else if (pick < 16) sc = 16'($urandom_range(0, n_structs));
      else if (pick < 18) sc = 16'(n_structs + $urandom_range(1, 3));
      else if (pick == 18) sc = 16'd0;
      else                sc = 16'hFFFF;

      pick = $urandom_range(0, 19);
      if (pick < 12)       tt = types[$urandom_range(0, types.size() - 1)];
      else if (pick < 16)  tt = 8'($urandom);
      else if (pick == 16) tt = EndType;
      else if (pick == 17) tt = 8'd0;
      else                 tt = 8'hFF;

      pick = $urandom_range(0, 19);
      if (pick < 10)      ml = 8'd0;
      else if (pick < 16) ml = 8'($urandom_range(0, 16));
      else if (pick < 18) ml = 8'($urandom);
      else                ml = 8'hFF;

      program_regs(tt, ml, tl, sc);
      play();
    end

    // drain: every verdict delivered, then a short tail for strays
    quiet = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("walked %0d table bytes into %0d verdict items", bytes_sent, verdicts_seen);
    $display("across %0d register settings, %0d failures", settings_count, errors);
    if (errors == 0 && pending == 0)
      $display("smbios_structure_locator: match");
    else
      $display("smbios_structure_locator: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_walk_step.sv
hw/rtl/smbios_structure_locator.sv
tb/smbios_structure_locator_check.sv
tb/smbios_structure_locator_test.sv
